// ----- design/integer_to_ascii_radix_unit_assert.svh -----
// assertion macros used by the conversion engine
`ifndef INTEGER_TO_ASCII_RADIX_UNIT_ASSERT_SVH
`define INTEGER_TO_ASCII_RADIX_UNIT_ASSERT_SVH

// property must hold at every rising clock edge out of reset
`define ITAR_ASSERT_HOLDS(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("property violated");

// expression must never be true out of reset
`define ITAR_ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");

`endif

// ----- design/itar_pkg.sv -----
// shared types, constants and helpers of the integer to ascii unit
package itar_pkg;

	localparam int VALUE_WIDTH_DEF = 32;
	localparam int RADIX_W         = 5;
	localparam int LEN_W           = 6;
	localparam int CHAR_W          = 8;
	localparam int DIGIT_W         = 4;
	localparam int OUT_DATA_W      = 16;
	localparam int DIV_STEP        = 8;

	localparam logic [RADIX_W-1:0] RADIX_RST = 5'd10;
	localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_UPPER = 8'h41;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
	localparam logic [DIGIT_W-1:0] DEC_TEN = 4'd10;

	typedef struct packed {
		logic bad;
		logic neg;
	} job_ctl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_SIGN,
		ST_DIGIT,
		ST_TERM,
		ST_ERR
	} back_state_t;

	function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] ch;
		if (d < DEC_TEN) begin
			ch = CH_ZERO + CHAR_W'(d);
		end else begin
			ch = CH_UPPER + CHAR_W'(d - DEC_TEN);
		end
		return ch;
	endfunction

endpackage

// ----- design/integer_to_ascii_radix_unit.sv -----
// top level of the signed integer to ascii text converter
//
// channel   | direction | handshake                     | payload
// s_axis    | in        | s_axis_tvalid / s_axis_tready | tdata: value
// m_axis    | out       | m_axis_tvalid / m_axis_tready | tdata: char_out, text_length
//           |           |                               | tlast: is_last, tuser: bad_radix
// cfg       | in        | cfg_valid / cfg_ready         | cfg_data: radix
//
// each digit comes from the byte-serial divider, a byte at a time (8 steps a cycle)
// a two-entry job queue lets the next request enter while one is converted
// output stall holds the engine in its output states; no clearing pass after reset
// digit buffer is read-first; reset is asynchronous and active low, radix comes up as 10
module integer_to_ascii_radix_unit #(
	parameter int VALUE_WIDTH = itar_pkg::VALUE_WIDTH_DEF,
	localparam int IN_DATA_W = ((VALUE_WIDTH + 7) / 8) * 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [IN_DATA_W-1:0]             s_axis_tdata,  // value
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [itar_pkg::OUT_DATA_W-1:0]  m_axis_tdata,  // char_out, text_length
	output logic                             m_axis_tlast,
	output logic                             m_axis_tuser,  // bad_radix
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [itar_pkg::RADIX_W-1:0]     cfg_data
);

	logic [itar_pkg::RADIX_W-1:0] radix_q;
	logic                         job_valid;
	logic                         job_ready;
	itar_pkg::job_ctl_t           job_ctl;
	logic [VALUE_WIDTH-1:0]       job_mag;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= itar_pkg::RADIX_RST;
		end else if (cfg_valid && cfg_ready) begin
			radix_q <= cfg_data;
		end
	end

	itar_front #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.radix        (radix_q),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.job_valid    (job_valid),
		.job_ready    (job_ready),
		.job_ctl      (job_ctl),
		.job_mag      (job_mag)
	);

	itar_back #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.radix        (radix_q),
		.job_valid    (job_valid),
		.job_ready    (job_ready),
		.job_ctl      (job_ctl),
		.job_mag      (job_mag),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.m_axis_tuser (m_axis_tuser)
	);

endmodule

// ----- design/itar_front.sv -----
// request intake: sign and magnitude split, radix check and a two-entry job queue
module itar_front #(
	parameter int VALUE_WIDTH = itar_pkg::VALUE_WIDTH_DEF,
	localparam int IN_DATA_W = ((VALUE_WIDTH + 7) / 8) * 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [itar_pkg::RADIX_W-1:0]  radix,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [IN_DATA_W-1:0]          s_axis_tdata,
	output logic                          job_valid,
	input  logic                          job_ready,
	output itar_pkg::job_ctl_t            job_ctl,
	output logic [VALUE_WIDTH-1:0]        job_mag
);

	logic [VALUE_WIDTH-1:0] value;
	logic [VALUE_WIDTH-1:0] mag;
	itar_pkg::job_ctl_t     ctl;
	logic                   push;
	logic                   pop;

	logic [VALUE_WIDTH-1:0] mag_fifo_q [2];
	itar_pkg::job_ctl_t     ctl_fifo_q [2];
	logic                   wr_ptr_q;
	logic                   rd_ptr_q;
	logic [1:0]             count_q;

	assign value   = s_axis_tdata[VALUE_WIDTH-1:0];
	assign ctl.neg = value[VALUE_WIDTH-1];
	assign ctl.bad = (radix < itar_pkg::RADIX_MIN) || (radix > itar_pkg::RADIX_MAX);
	assign mag     = ctl.neg ? (~value + VALUE_WIDTH'(1)) : value;

	assign s_axis_tready = (count_q != 2'd2);
	assign job_valid     = (count_q != 2'd0);
	assign push          = s_axis_tvalid && s_axis_tready;
	assign pop           = job_valid && job_ready;
	assign job_ctl       = ctl_fifo_q[rd_ptr_q];
	assign job_mag       = mag_fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mag_fifo_q[wr_ptr_q] <= mag;
			ctl_fifo_q[wr_ptr_q] <= ctl;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

// ----- design/itar_back.sv -----
// conversion engine: digit-serial division by the radix, digit buffer and character output
`include "integer_to_ascii_radix_unit_assert.svh"

module itar_back #(
	parameter int VALUE_WIDTH = itar_pkg::VALUE_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [itar_pkg::RADIX_W-1:0]     radix,
	input  logic                             job_valid,
	output logic                             job_ready,
	input  itar_pkg::job_ctl_t               job_ctl,
	input  logic [VALUE_WIDTH-1:0]           job_mag,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [itar_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	output logic                             m_axis_tlast,
	output logic                             m_axis_tuser
);

	localparam int STEP = itar_pkg::DIV_STEP;
	localparam int PW   = ((VALUE_WIDTH + STEP - 1) / STEP) * STEP;
	localparam int NCH  = PW / STEP;
	localparam int CHW  = (NCH > 1) ? $clog2(NCH) : 1;
	localparam int AW   = $clog2(VALUE_WIDTH);
	localparam int CW   = $clog2(VALUE_WIDTH + 1);
	localparam int DW   = itar_pkg::DIGIT_W;
	localparam int LW   = itar_pkg::LEN_W;
	localparam int CHR  = itar_pkg::CHAR_W;

	itar_pkg::back_state_t state_q;
	itar_pkg::back_state_t state_nx;

	logic [PW-1:0]   mag_q;
	logic [DW-1:0]   rem_q;
	logic [CHW-1:0]  chunk_q;
	logic [CW-1:0]   cnt_q;
	logic [LW-1:0]   len_q;
	logic            neg_q;

	logic [DW-1:0]   dig_mem [VALUE_WIDTH];
	logic [DW-1:0]   rd_q;
	logic [AW-1:0]   rd_addr;

	logic [DW-1:0]   r_step;
	logic [DW:0]     t_step;
	logic [STEP-1:0] qbits;
	logic [PW-1:0]   mag_nx;
	logic            last_chunk;
	logic            stop_div;
	logic            dig_we;

	logic            out_free;
	logic            out_load;
	logic [CHR-1:0]  out_char;
	logic            out_last;
	logic [LW-1:0]   out_len;
	logic            out_bad;

	logic            ovalid_q;
	logic [CHR-1:0]  ochar_q;
	logic            olast_q;
	logic [LW-1:0]   olen_q;
	logic            obad_q;

	// eight restoring steps on the top byte of the magnitude
	always_comb begin
		r_step = rem_q;
		t_step = '0;
		qbits  = '0;
		for (int i = 0; i < STEP; i++) begin
			t_step = {r_step, mag_q[PW-1-i]};
			if (t_step >= radix) begin
				qbits[STEP-1-i] = 1'b1;
				r_step = DW'(t_step - radix);
			end else begin
				r_step = DW'(t_step);
			end
		end
	end

	assign mag_nx     = (mag_q << STEP) | PW'(qbits);
	assign last_chunk = (chunk_q == CHW'(NCH - 1));
	assign stop_div   = (mag_nx == '0) || ((cnt_q + CW'(1)) == CW'(VALUE_WIDTH));
	assign dig_we     = (state_q == itar_pkg::ST_DIV) && last_chunk;
	assign out_free   = !ovalid_q || m_axis_tready;

	always_comb begin
		if ((state_q == itar_pkg::ST_DIGIT) && out_free) begin
			rd_addr = AW'(cnt_q - CW'(2));
		end else begin
			rd_addr = AW'(cnt_q - CW'(1));
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			itar_pkg::ST_IDLE: begin
				if (job_valid) begin
					state_nx = job_ctl.bad ? itar_pkg::ST_ERR : itar_pkg::ST_DIV;
				end
			end
			itar_pkg::ST_DIV: begin
				if (last_chunk && stop_div) begin
					state_nx = itar_pkg::ST_SIGN;
				end
			end
			itar_pkg::ST_SIGN: begin
				if (!neg_q || out_free) begin
					state_nx = itar_pkg::ST_DIGIT;
				end
			end
			itar_pkg::ST_DIGIT: begin
				if (out_free && (cnt_q == CW'(1))) begin
					state_nx = itar_pkg::ST_TERM;
				end
			end
			itar_pkg::ST_TERM, itar_pkg::ST_ERR: begin
				if (out_free) begin
					state_nx = itar_pkg::ST_IDLE;
				end
			end
			default: state_nx = itar_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		job_ready = 1'b0;
		out_load  = 1'b0;
		out_char  = itar_pkg::CH_NUL;
		out_last  = 1'b0;
		out_len   = '0;
		out_bad   = 1'b0;
		unique case (state_q)
			itar_pkg::ST_IDLE: begin
				job_ready = 1'b1;
			end
			itar_pkg::ST_DIV: begin
			end
			itar_pkg::ST_SIGN: begin
				out_load = neg_q && out_free;
				out_char = itar_pkg::CH_MINUS;
			end
			itar_pkg::ST_DIGIT: begin
				out_load = out_free;
				out_char = itar_pkg::digit_char(rd_q);
			end
			itar_pkg::ST_TERM: begin
				out_load = out_free;
				out_last = 1'b1;
				out_len  = len_q + LW'(1);
			end
			itar_pkg::ST_ERR: begin
				out_load = out_free;
				out_last = 1'b1;
				out_bad  = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= itar_pkg::ST_IDLE;
			chunk_q  <= '0;
			cnt_q    <= '0;
			len_q    <= '0;
			neg_q    <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			unique case (state_q)
				itar_pkg::ST_IDLE: begin
					if (job_valid) begin
						chunk_q <= '0;
						cnt_q   <= '0;
						len_q   <= '0;
						neg_q   <= job_ctl.neg;
					end
				end
				itar_pkg::ST_DIV: begin
					if (last_chunk) begin
						chunk_q <= '0;
						cnt_q   <= cnt_q + CW'(1);
					end else begin
						chunk_q <= chunk_q + CHW'(1);
					end
				end
				itar_pkg::ST_SIGN: begin
					if (out_load) begin
						len_q <= len_q + LW'(1);
					end
				end
				itar_pkg::ST_DIGIT: begin
					if (out_load) begin
						cnt_q <= cnt_q - CW'(1);
						len_q <= len_q + LW'(1);
					end
				end
				default: begin
				end
			endcase
			if (out_load) begin
				ovalid_q <= 1'b1;
			end else if (m_axis_tready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == itar_pkg::ST_IDLE) && job_valid) begin
			mag_q <= PW'(job_mag);
			rem_q <= '0;
		end else if (state_q == itar_pkg::ST_DIV) begin
			mag_q <= mag_nx;
			rem_q <= last_chunk ? '0 : r_step;
		end
		if (out_load) begin
			ochar_q <= out_char;
			olast_q <= out_last;
			olen_q  <= out_len;
			obad_q  <= out_bad;
		end
	end

	always_ff @(posedge clk) begin
		if (dig_we) begin
			dig_mem[cnt_q[AW-1:0]] <= r_step;
		end
		rd_q <= dig_mem[rd_addr];
	end

	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata  = {2'b00, olen_q, ochar_q};
	assign m_axis_tlast  = olast_q;
	assign m_axis_tuser  = obad_q;

	`ITAR_ASSERT_NEVER(a_digit_empty, clk, arst_n, (state_q == itar_pkg::ST_DIGIT) && (cnt_q == '0))
	`ITAR_ASSERT_HOLDS(a_cnt_bound, clk, arst_n, cnt_q <= CW'(VALUE_WIDTH))
	`ITAR_ASSERT_HOLDS(a_rem_bound, clk, arst_n, (state_q == itar_pkg::ST_DIV) |-> (rem_q < radix))
	`ITAR_ASSERT_HOLDS(a_err_shape, clk, arst_n, (ovalid_q && obad_q) |-> (olast_q && (olen_q == '0)))

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps
// testbench of the integer to ascii radix converter: directed table, then random phases
module tb;

	localparam int VW          = 32;
	localparam int WATCH_LIMIT = 4000;
	localparam int HOLD_LEN    = 400;
	localparam int SETTLE      = 40;
	localparam int TAIL        = 200;
	localparam int DIR_N       = 21;
	localparam int PHASES      = 10;
	localparam int PHASE_ITEMS = 13;
	localparam int SHOW_MAX    = 10;
	localparam int RW          = itar_pkg::RADIX_W;
	localparam int CW          = itar_pkg::CHAR_W;
	localparam int LW          = itar_pkg::LEN_W;
	localparam int DW          = itar_pkg::DIGIT_W;
	localparam int ODW         = itar_pkg::OUT_DATA_W;

	typedef enum logic [1:0] {
		CHK_MODEL,
		CHK_TEXT,
		CHK_ERROR
	} row_check_t;

	typedef struct {
		logic [RW-1:0] radix;
		logic [VW-1:0] value;
		row_check_t    check;
		string         text;
	} dir_row_t;

	typedef struct packed {
		logic [CW-1:0] ch;
		logic          last;
		logic [LW-1:0] len;
		logic          bad;
	} text_char_t;

	logic           clk;
	logic           arst_n = 1'b0;
	logic           s_axis_tvalid = 1'b0;
	logic           s_axis_tready;
	logic [VW-1:0]  s_axis_tdata = '0;  // value
	logic           m_axis_tvalid;
	logic           m_axis_tready = 1'b0;
	logic [ODW-1:0] m_axis_tdata;  // char_out, text_length, zero fill
	logic           m_axis_tlast;
	logic           m_axis_tuser;  // bad_radix
	logic           cfg_valid = 1'b0;
	logic           cfg_ready;
	logic [RW-1:0]  cfg_data = itar_pkg::RADIX_RST;

	text_char_t    expected_chars [$];
	text_char_t    want;
	logic [RW-1:0] radix_now = itar_pkg::RADIX_RST;
	int            mismatches = 0;
	int            send_idle_pct = 0;
	int            recv_idle_pct = 0;
	logic          hold_req = 1'b0;
	logic          hold_seen = 1'b0;
	int            hold_left = 0;
	int            quiet_cycles = 0;
	dir_row_t      dir_rows [DIR_N];

	integer_to_ascii_radix_unit #(
		.VALUE_WIDTH(VW)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.m_axis_tuser (m_axis_tuser),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic void push_char(input logic [CW-1:0] ch, input logic last,
			input logic [LW-1:0] len, input logic bad);
		expected_chars.push_back('{ch, last, len, bad});
	endfunction

	function automatic void push_bad_radix();
		push_char(itar_pkg::CH_NUL, 1'b1, '0, 1'b1);
	endfunction

	function automatic void push_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			push_char(s[i], 1'b0, '0, 1'b0);
		end
		push_char(itar_pkg::CH_NUL, 1'b1, LW'(s.len() + 1), 1'b0);
	endfunction

	// error if bad radix; else divide, then sign, digits msb first, terminator
	function automatic void predict_text(input logic [VW-1:0] v);
		logic [VW-1:0] mag;
		logic [DW-1:0] digs [VW];
		logic [DW-1:0] d;
		logic          neg;
		int            n;
		int            k;
		if (radix_now < itar_pkg::RADIX_MIN || radix_now > itar_pkg::RADIX_MAX) begin
			push_bad_radix();
			return;
		end
		neg = v[VW-1];
		mag = neg ? -v : v;
		n = 0;
		do begin
			digs[n] = DW'(mag % radix_now);
			mag = mag / radix_now;
			n++;
		end while (mag != 0 && n < VW);
		k = 0;
		if (neg) begin
			push_char(itar_pkg::CH_MINUS, 1'b0, '0, 1'b0);
			k++;
		end
		for (int i = n - 1; i >= 0; i--) begin
			d = digs[i];
			push_char((d < itar_pkg::DEC_TEN) ? itar_pkg::CH_ZERO + CW'(d)
				: itar_pkg::CH_UPPER + CW'(d - itar_pkg::DEC_TEN),
				1'b0, '0, 1'b0);
			k++;
		end
		push_char(itar_pkg::CH_NUL, 1'b1, LW'(k + 1), 1'b0);
	endfunction

	function automatic logic [VW-1:0] rand_value();
		logic [VW-1:0] v;
		case ($urandom_range(0, 4))
			0: begin
				v = $urandom;
			end
			1: begin
				v = $urandom_range(0, 40);
			end
			2: begin
				v = -VW'($urandom_range(1, 40));
			end
			3: begin
				if ($urandom_range(0, 1) != 0) begin
					v = 32'h8000_0000 + $urandom_range(0, 3);
				end else begin
					v = 32'h7FFF_FFFF - $urandom_range(0, 3);
				end
			end
			default: begin
				v = $urandom >> $urandom_range(0, VW - 1);
				if ($urandom_range(0, 1) != 0) begin
					v = -v;
				end
			end
		endcase
		return v;
	endfunction

	task automatic send_value(input logic [VW-1:0] v, input row_check_t check,
			input string text);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= v;
		do @(posedge clk); while (!s_axis_tready);
		case (check)
			CHK_TEXT: begin
				push_text(text);
			end
			CHK_ERROR: begin
				push_bad_radix();
			end
			default: begin
				predict_text(v);
			end
		endcase
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (expected_chars.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_radix(input logic [RW-1:0] r);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data  <= r;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		radix_now = r;
	endtask

	task automatic note_mismatch(input string field, input int unsigned exp_v,
			input int unsigned act_v);
		mismatches++;
		if (mismatches <= SHOW_MAX) begin
			$display("mismatch in %s: expected %0d, got %0d", field, exp_v, act_v);
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (hold_req != hold_seen) begin
			hold_seen     <= hold_req;
			hold_left     <= HOLD_LEN;
			m_axis_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left     <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_chars.size() == 0) begin
				note_mismatch("unexpected character", 0, m_axis_tdata[CW-1:0]);
			end else begin
				want = expected_chars.pop_front();
				if (m_axis_tdata[CW-1:0] !== want.ch) begin
					note_mismatch("char_out", want.ch, m_axis_tdata[CW-1:0]);
				end
				if (m_axis_tlast !== want.last) begin
					note_mismatch("is_last", want.last, m_axis_tlast);
				end
				if (m_axis_tdata[CW+LW-1:CW] !== want.len) begin
					note_mismatch("text_length", want.len, m_axis_tdata[CW+LW-1:CW]);
				end
				if (m_axis_tuser !== want.bad) begin
					note_mismatch("bad_radix", want.bad, m_axis_tuser);
				end
				if (m_axis_tdata[ODW-1:CW+LW] !== '0) begin
					note_mismatch("tdata fill", 0, m_axis_tdata[ODW-1:CW+LW]);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCH_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		logic [RW-1:0] r;
		dir_rows = '{
			'{5'd10, 32'd0,         CHK_TEXT,  "0"},
			'{5'd10, 32'h7FFF_FFFF, CHK_TEXT,  "2147483647"},
			'{5'd10, 32'h8000_0000, CHK_TEXT,  "-2147483648"},
			'{5'd10, 32'hFFFF_FFFF, CHK_TEXT,  "-1"},
			'{5'd10, 32'd123456789, CHK_MODEL, ""},
			'{5'd16, 32'h7FFF_FFFF, CHK_TEXT,  "7FFFFFFF"},
			'{5'd16, 32'h8000_0000, CHK_TEXT,  "-80000000"},
			'{5'd16, 32'hFFFF_FFFF, CHK_TEXT,  "-1"},
			'{5'd16, 32'h0ABC_DEF9, CHK_MODEL, ""},
			'{5'd2,  32'h8000_0000, CHK_MODEL, ""},
			'{5'd2,  32'h7FFF_FFFF, CHK_MODEL, ""},
			'{5'd2,  32'd0,         CHK_TEXT,  "0"},
			'{5'd0,  32'd5,         CHK_ERROR, ""},
			'{5'd1,  32'hFFFF_FFF9, CHK_ERROR, ""},
			'{5'd17, 32'd0,         CHK_ERROR, ""},
			'{5'd31, 32'h7FFF_FFFF, CHK_ERROR, ""},
			'{5'd3,  32'h8000_0000, CHK_MODEL, ""},
			'{5'd7,  32'd12345,     CHK_MODEL, ""},
			'{5'd15, 32'hFFFE_7961, CHK_MODEL, ""},
			'{5'd9,  32'h5555_5555, CHK_MODEL, ""},
			'{5'd10, 32'hAAAA_AAAA, CHK_MODEL, ""}
		};
		send_idle_pct = 21;
		recv_idle_pct = 47;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_N; i++) begin
			if (dir_rows[i].radix != radix_now) begin
				write_radix(dir_rows[i].radix);
			end
			send_value(dir_rows[i].value, dir_rows[i].check, dir_rows[i].text);
		end

		for (int p = 0; p < PHASES; p++) begin
			if (p < 4) begin
				send_idle_pct = 21;
				recv_idle_pct = 47;
			end else if (p < 7) begin
				send_idle_pct = 47;
				recv_idle_pct = 21;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			case (p)
				1: r = itar_pkg::RADIX_MIN;
				2: r = itar_pkg::RADIX_MAX;
				3: r = itar_pkg::RADIX_RST;
				default: begin
					if ($urandom_range(0, 4) == 0) begin
						r = ($urandom_range(0, 1) != 0) ? RW'($urandom_range(0, 1))
							: RW'($urandom_range(17, 31));
					end else begin
						r = RW'($urandom_range(2, 16));
					end
				end
			endcase
			if (r != radix_now) begin
				write_radix(r);
			end
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (p == 3 && i == 3) begin
					hold_req <= ~hold_req;
				end
				send_value(rand_value(), CHK_MODEL, "");
			end
		end

		s_axis_tvalid <= 1'b0;
		while (expected_chars.size() != 0) @(posedge clk);
		repeat (TAIL) @(posedge clk);
		if (mismatches == 0 && expected_chars.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+design
design/itar_pkg.sv
design/itar_front.sv
design/itar_back.sv
design/integer_to_ascii_radix_unit.sv
test/tb.sv
